// ----- hdl/pfe_pkg.sv -----
// Shared constants, types and letter/cell helper functions for the Playfair encryptor.
package pfe_pkg;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int LETTER_W   = 5;
  localparam int CELL_W     = 5;
  localparam int COORD_W    = 3;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;
  localparam logic [LETTER_W-1:0] LETTERS  = 5'd26;
  localparam logic [CELL_W-1:0]   CELLS    = 5'd25;
  localparam logic [COORD_W-1:0]  SIDE_MAX = 3'd4;

  localparam int NUM_LETTERS = 26;
  localparam int NUM_CELLS   = 25;

  // Request kinds carried on the input tuser bit.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pos_t;

  localparam int POS_W = $bits(pos_t);

  // Clamp out-of-range codes to Z and fold J into I.
  function automatic logic [LETTER_W-1:0] norm_letter(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    if (c == LETTER_J) begin
      c = LETTER_I;
    end
    return c;
  endfunction

  // Row-major cell index of a square position.
  function automatic logic [CELL_W-1:0] cell_of(input pos_t p);
    logic [CELL_W-1:0] r;
    r = {2'b00, p.row};
    return (r << 2) + r + {2'b00, p.col};
  endfunction

  // Next position in row order.
  function automatic pos_t pos_next(input pos_t p);
    pos_t n;
    if (p.col == SIDE_MAX) begin
      n.row = p.row + 3'd1;
      n.col = '0;
    end else begin
      n.row = p.row;
      n.col = p.col + 3'd1;
    end
    return n;
  endfunction

  // Position of a letter in the reset square (alphabet without J).
  function automatic pos_t default_pos(input logic [LETTER_W-1:0] letter);
    logic [CELL_W-1:0]  idx;
    logic [COORD_W-1:0] row;
    logic [CELL_W-1:0]  base;
    pos_t p;
    idx = (letter > LETTER_J) ? letter - 5'd1 : letter;
    row = 3'({2'b00, (idx >= 5'd5)} + {2'b00, (idx >= 5'd10)} +
             {2'b00, (idx >= 5'd15)} + {2'b00, (idx >= 5'd20)});
    base = ({2'b00, row} << 2) + {2'b00, row};
    p.row = row;
    p.col = COORD_W'(idx - base);
    return p;
  endfunction

  // Letter held by a cell of the reset square.
  function automatic logic [LETTER_W-1:0] default_letter(input logic [CELL_W-1:0] cell_idx);
    return (cell_idx < LETTER_J) ? cell_idx : cell_idx + 5'd1;
  endfunction

endpackage

// ----- hdl/playfair_cipher_encrypt.sv -----
// Playfair encryptor top level: sequencer, key square storage and output register.
// A key letter is taken while idle; the last key letter starts a completion walk of
// one candidate letter per cycle, written in that cycle, before the next request.
// The first letter of a pair is only held; the second is encrypted by two
// position-RAM reads and two square-RAM reads in turn; a lone final letter takes the same path.
// Synchronous active-low reset empties the pipeline and restores the alphabetic square.
module playfair_cipher_encrypt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pfe_pkg::IN_DATA_W-1:0]    in_tdata,   // [4:0] letter, [7:5] zero
  input  logic                             in_tuser,   // [0] operation: 0 key, 1 text
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pfe_pkg::OUT_DATA_W-1:0]   out_tdata,  // [4:0] first_cipher, [9:5] second_cipher
  output logic                             out_tlast   // text_end
);
  import pfe_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,  // waiting for a request
    ST_FILL = 7'b0000010,  // completing the square with unused letters
    ST_TXT  = 7'b0000100,  // pairing decision, look up first letter
    ST_LB   = 7'b0001000,  // look up second letter
    ST_CA   = 7'b0010000,  // apply the rule, read first cipher cell
    ST_CB   = 7'b0100000,  // read second cipher cell
    ST_FIN  = 7'b1000000   // hand the pair to the output register
  } state_t;

  state_t state_r, state_nxt;

  logic                    held_valid_r, held_valid_nxt;
  logic [LETTER_W-1:0]     held_letter_r, held_letter_nxt;
  logic                    key_open_r, key_open_nxt;
  // Set once any key has been loaded; until then lookups use the reset square.
  logic                    custom_r, custom_nxt;
  logic [CELL_W-1:0]       fill_cnt_r, fill_cnt_nxt;
  pos_t                    fill_pos_r, fill_pos_nxt;
  logic [NUM_LETTERS-1:0]  used_r, used_nxt;
  logic [LETTER_W-1:0]     scan_r, scan_nxt;
  logic                    pend_r, pend_nxt;
  logic [LETTER_W-1:0]     cur_letter_r, cur_letter_nxt;
  logic                    cur_last_r, cur_last_nxt;
  logic [LETTER_W-1:0]     b_r, b_nxt;
  logic                    last_pair_r, last_pair_nxt;
  pos_t                    pa_r, pa_nxt;
  logic [CELL_W-1:0]       c2_r, c2_nxt;
  logic [LETTER_W-1:0]     o1_r, o1_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0]     out_first_r, out_first_nxt;
  logic [LETTER_W-1:0]     out_second_r, out_second_nxt;
  logic                    out_last_r, out_last_nxt;
  pos_t                    pos_def_r;
  logic [LETTER_W-1:0]     sq_def_r;

  // Square storage: cell -> letter, and the inverse map letter -> position.
  logic                    sq_we;
  logic [CELL_W-1:0]       sq_waddr, sq_raddr;
  logic [LETTER_W-1:0]     sq_wdata, sq_rdata;
  logic                    pos_we;
  logic [LETTER_W-1:0]     pos_waddr, pos_raddr;
  logic [POS_W-1:0]        pos_wdata, pos_rdata;

  logic                    accept;
  logic [LETTER_W-1:0]     in_ch;
  logic [NUM_LETTERS-1:0]  eff_used;
  logic [CELL_W-1:0]       eff_fill;
  pos_t                    eff_fpos;
  pos_t                    pos_eff;
  logic [LETTER_W-1:0]     sq_eff;
  logic                    scan_free;
  logic [CELL_W-1:0]       rule_cell_a, rule_cell_b;

  pfe_ram #(.WIDTH(LETTER_W), .DEPTH(NUM_CELLS)) u_square (
    .clk   (clk),
    .we    (sq_we),
    .waddr (sq_waddr),
    .wdata (sq_wdata),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  pfe_ram #(.WIDTH(POS_W), .DEPTH(NUM_LETTERS)) u_position (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  pfe_rule u_rule (
    .pos_a  (pa_r),
    .pos_b  (pos_eff),
    .cell_a (rule_cell_a),
    .cell_b (rule_cell_b)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign in_ch      = norm_letter(in_tdata[LETTER_W-1:0]);

  // A new key starts from an empty map and the first cell.
  assign eff_used   = key_open_r ? used_r : '0;
  assign eff_fill   = key_open_r ? fill_cnt_r : '0;
  assign eff_fpos   = key_open_r ? fill_pos_r : '0;

  // Read data from the RAMs, or from the reset square before any key was loaded.
  assign pos_eff    = custom_r ? pos_t'(pos_rdata) : pos_def_r;
  assign sq_eff     = custom_r ? sq_rdata : sq_def_r;

  assign scan_free  = (scan_r < LETTERS) && (scan_r != LETTER_J) && !used_r[scan_r];

  always_comb begin
    state_nxt       = state_r;
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    key_open_nxt    = key_open_r;
    custom_nxt      = custom_r;
    fill_cnt_nxt    = fill_cnt_r;
    fill_pos_nxt    = fill_pos_r;
    used_nxt        = used_r;
    scan_nxt        = scan_r;
    pend_nxt        = pend_r;
    cur_letter_nxt  = cur_letter_r;
    cur_last_nxt    = cur_last_r;
    b_nxt           = b_r;
    last_pair_nxt   = last_pair_r;
    pa_nxt          = pa_r;
    c2_nxt          = c2_r;
    o1_nxt          = o1_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_last_nxt    = out_last_r;

    sq_we     = 1'b0;
    sq_waddr  = fill_cnt_r;
    sq_wdata  = scan_r;
    pos_we    = 1'b0;
    pos_waddr = scan_r;
    pos_wdata = fill_pos_r;
    pos_raddr = b_r;
    sq_raddr  = c2_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_KEY) begin
            // A key letter drops any held plaintext letter.
            held_valid_nxt = 1'b0;
            key_open_nxt   = 1'b1;
            custom_nxt     = 1'b1;
            used_nxt       = eff_used;
            fill_cnt_nxt   = eff_fill;
            fill_pos_nxt   = eff_fpos;
            if (!eff_used[in_ch] && (eff_fill < CELLS)) begin
              sq_we           = 1'b1;
              sq_waddr        = eff_fill;
              sq_wdata        = in_ch;
              pos_we          = 1'b1;
              pos_waddr       = in_ch;
              pos_wdata       = eff_fpos;
              used_nxt[in_ch] = 1'b1;
              fill_cnt_nxt    = eff_fill + 5'd1;
              fill_pos_nxt    = pos_next(eff_fpos);
            end
            if (in_tlast) begin
              scan_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_FILL;
            end
          end else begin
            cur_letter_nxt = in_ch;
            cur_last_nxt   = in_tlast;
            if (key_open_r) begin
              // Plaintext during key loading completes the square first.
              scan_nxt  = '0;
              pend_nxt  = 1'b1;
              state_nxt = ST_FILL;
            end else begin
              state_nxt = ST_TXT;
            end
          end
        end
      end

      ST_FILL: begin
        if ((fill_cnt_r == CELLS) || (scan_r >= LETTERS)) begin
          fill_cnt_nxt = CELLS;
          key_open_nxt = 1'b0;
          state_nxt    = pend_r ? ST_TXT : ST_IDLE;
        end else begin
          scan_nxt = scan_r + 5'd1;
          if (scan_free) begin
            sq_we            = 1'b1;
            pos_we           = 1'b1;
            used_nxt[scan_r] = 1'b1;
            fill_cnt_nxt     = fill_cnt_r + 5'd1;
            fill_pos_nxt     = pos_next(fill_pos_r);
          end
        end
      end

      ST_TXT: begin
        if (!held_valid_r && !cur_last_r) begin
          held_letter_nxt = cur_letter_r;
          held_valid_nxt  = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          // A lone final letter is paired with X.
          pos_raddr      = held_valid_r ? held_letter_r : cur_letter_r;
          b_nxt          = held_valid_r ? cur_letter_r : LETTER_X;
          held_valid_nxt = 1'b0;
          last_pair_nxt  = cur_last_r;
          state_nxt      = ST_LB;
        end
      end

      ST_LB: begin
        pa_nxt    = pos_eff;
        pos_raddr = b_r;
        state_nxt = ST_CA;
      end

      ST_CA: begin
        sq_raddr  = rule_cell_a;
        c2_nxt    = rule_cell_b;
        state_nxt = ST_CB;
      end

      ST_CB: begin
        o1_nxt    = sq_eff;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // The read address stays on the second cell while the output is full.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = o1_r;
          out_second_nxt = sq_eff;
          out_last_nxt   = last_pair_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_valid_r <= 1'b0;
      key_open_r   <= 1'b0;
      custom_r     <= 1'b0;
      fill_cnt_r   <= '0;
      used_r       <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      key_open_r   <= key_open_nxt;
      custom_r     <= custom_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      used_r       <= used_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    held_letter_r <= held_letter_nxt;
    fill_pos_r    <= fill_pos_nxt;
    scan_r        <= scan_nxt;
    cur_letter_r  <= cur_letter_nxt;
    cur_last_r    <= cur_last_nxt;
    b_r           <= b_nxt;
    last_pair_r   <= last_pair_nxt;
    pa_r          <= pa_nxt;
    c2_r          <= c2_nxt;
    o1_r          <= o1_nxt;
    out_first_r   <= out_first_nxt;
    out_second_r  <= out_second_nxt;
    out_last_r    <= out_last_nxt;
    pos_def_r     <= default_pos(pos_raddr);
    sq_def_r      <= default_letter(sq_raddr);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_second_r, out_first_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A plaintext request always moves the sequencer out of idle, holding off further requests.
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == OP_TEXT)) |=> !in_tready)
    else $error("plaintext request did not hold off the next request");

  // The fill pointer never runs past the square.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CELLS)
    else $error("fill count beyond the square");

  // Pair lookups only run on a completed square.
  a_lookup_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LB) |-> !key_open_r)
    else $error("lookup started while the key was still open");

  // Cipher letters are always valid letter codes.
  a_out_letters: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[4:0] <= LETTER_Z) && (out_tdata[9:5] <= LETTER_Z)))
    else $error("cipher letter out of range");
`endif

endmodule

// ----- hdl/pfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pfe_rule.sv -----
// Playfair pair rule: maps the positions of a letter pair to the two cipher cells.
module pfe_rule (
  input  pfe_pkg::pos_t               pos_a,
  input  pfe_pkg::pos_t               pos_b,
  output logic [pfe_pkg::CELL_W-1:0]  cell_a,
  output logic [pfe_pkg::CELL_W-1:0]  cell_b
);
  import pfe_pkg::*;

  pos_t out_a;
  pos_t out_b;

  function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] v);
    return (v == SIDE_MAX) ? '0 : v + 3'd1;
  endfunction

  always_comb begin
    out_a = pos_a;
    out_b = pos_b;
    if (pos_a.row == pos_b.row) begin
      out_a.col = wrap_inc(pos_a.col);
      out_b.col = wrap_inc(pos_b.col);
    end else if (pos_a.col == pos_b.col) begin
      out_a.row = wrap_inc(pos_a.row);
      out_b.row = wrap_inc(pos_b.row);
    end else begin
      out_a.col = pos_b.col;
      out_b.col = pos_a.col;
    end
  end

  assign cell_a = cell_of(out_a);
  assign cell_b = cell_of(out_b);

endmodule
